// ===== rtl/core/tqc_pkg.sv =====
// Package: types, constants and helpers shared by the two-queue replacement block.
package tqc_pkg;

  // List depths and key width.
  localparam int unsigned IN_DEPTH   = 8;
  localparam int unsigned OUT_DEPTH  = 8;
  localparam int unsigned HOT_DEPTH  = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned PAGE_KEY_W = 32;
  localparam int unsigned KEY_W      = (KEY_BITS < PAGE_KEY_W) ? KEY_BITS : PAGE_KEY_W;

  // Count / limit widths: hold 0..DEPTH.
  localparam int unsigned IN_CW  = $clog2(IN_DEPTH + 1);
  localparam int unsigned OUT_CW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned HOT_CW = $clog2(HOT_DEPTH + 1);

  // Slot index width of the In list.
  localparam int unsigned IN_IW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;

  // Register field widths and reset values.
  localparam int unsigned IN_LIM_FW  = 4;
  localparam int unsigned OUT_LIM_FW = 4;
  localparam int unsigned HOT_LIM_FW = 5;
  localparam int unsigned LIM_ARG_W  = 5;
  localparam logic [LIM_ARG_W-1:0] IN_LIM_RST  = 5'd8;
  localparam logic [LIM_ARG_W-1:0] OUT_LIM_RST = 5'd8;
  localparam logic [LIM_ARG_W-1:0] HOT_LIM_RST = 5'd16;

  // APB side.
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    CFG_IN_LIMIT  = 2'd0,
    CFG_OUT_LIMIT = 2'd1,
    CFG_HOT_LIMIT = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    REG_MISS = 2'd0,
    REG_IN   = 2'd1,
    REG_OUT  = 2'd2,
    REG_HOT  = 2'd3
  } region_t;

  // Per-cell update: keep, take from the head side, take from the tail side.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PREV = 2'd1,
    CELL_NEXT = 2'd2
  } cell_op_t;

  // Active list limits, already clamped to 1..DEPTH.
  typedef struct packed {
    logic [IN_CW-1:0]  in_lim;
    logic [OUT_CW-1:0] out_lim;
    logic [HOT_CW-1:0] hot_lim;
  } lim_t;

  // 0 acts as 1, anything above the depth acts as the depth.
  function automatic int unsigned clamp_lim(input logic [LIM_ARG_W-1:0] v,
                                            input int unsigned depth);
    int unsigned r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > depth) r = depth;
    return r;
  endfunction

endpackage

// ===== rtl/core/two_queue_cache_replacement.sv =====
// Top level of the two-queue (In / Out / Hot) page cache replacement block.
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+------------------------------
//  in      | in_valid, in_stall, in_page_key         | in_valid & !in_stall
//  out     | out_valid, out_stall, out_hit,          | out_valid & !out_stall
//          | out_found_region                        |
//  cfg     | psel, penable, pwrite, paddr, pwdata,   | psel & penable & pwrite
//          | prdata, pready                          |
//
// Flow: a key is captured in the request register, then looked up and applied to
// the lists once the output register is free or being taken, and its result is
// registered in the output register; one key per cycle sustained while out_stall is low.
// The speed limit is the parallel compare across all cells feeding the shift
// controls of every cell.
// Reset: synchronous, active low; clears counts and valids, limits go to 8/8/16.
// Stalls: a held output blocks the lookup, which in turn holds the request
// register and raises in_stall.
module two_queue_cache_replacement
  import tqc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAGE_KEY_W-1:0] in_page_key,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [1:0]            out_found_region,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  lim_t lim;

  tqc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .lim     (lim)
  );

  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Request register and output register
  // ---------------------------------------------------------------------------
  logic    req_valid_r, req_valid_nxt;
  key_t    req_key_r;
  logic    out_valid_r, out_valid_nxt;
  logic    out_hit_r;
  region_t out_region_r;
  logic    fire;    // lookup + list update this cycle
  logic    in_xfer;
  region_t region;

  assign fire     = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !fire;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    req_valid_nxt = in_xfer || (req_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) req_key_r <= in_page_key[KEY_W-1:0];
    if (fire) begin
      out_hit_r    <= (region != REG_MISS);
      out_region_r <= region;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_found_region = out_region_r;

  // ---------------------------------------------------------------------------
  // List counts. A limit lowered below its count cuts the count right away, so
  // every use goes through the effective (clamped) count.
  // ---------------------------------------------------------------------------
  logic [IN_CW-1:0]  in_cnt_r,  in_cnt_nxt,  in_eff;
  logic [OUT_CW-1:0] out_cnt_r, out_cnt_nxt, out_eff;
  logic [HOT_CW-1:0] hot_cnt_r, hot_cnt_nxt, hot_eff;

  assign in_eff  = (in_cnt_r  > lim.in_lim)  ? lim.in_lim  : in_cnt_r;
  assign out_eff = (out_cnt_r > lim.out_lim) ? lim.out_lim : out_cnt_r;
  assign hot_eff = (hot_cnt_r > lim.hot_lim) ? lim.hot_lim : hot_cnt_r;

  // ---------------------------------------------------------------------------
  // Cell chains
  // ---------------------------------------------------------------------------
  key_t     in_key   [IN_DEPTH];
  key_t     in_prev  [IN_DEPTH];
  key_t     in_next  [IN_DEPTH];
  cell_op_t in_op    [IN_DEPTH];
  logic     [IN_DEPTH-1:0] in_eq, in_m;

  key_t     out_key  [OUT_DEPTH];
  key_t     out_prev [OUT_DEPTH];
  key_t     out_next [OUT_DEPTH];
  cell_op_t out_op   [OUT_DEPTH];
  logic     [OUT_DEPTH-1:0] out_eq, out_m, out_pre;

  key_t     hot_key  [HOT_DEPTH];
  key_t     hot_prev [HOT_DEPTH];
  key_t     hot_next [HOT_DEPTH];
  cell_op_t hot_op   [HOT_DEPTH];
  logic     [HOT_DEPTH-1:0] hot_eq, hot_m, hot_suf;

  for (genvar i = 0; i < IN_DEPTH; i++) begin : g_in
    tqc_cell u_cell (
      .clk (clk), .op (in_op[i]), .prev_key (in_prev[i]), .next_key (in_next[i]),
      .look_key (req_key_r), .key_o (in_key[i]), .match_o (in_eq[i])
    );
  end

  for (genvar i = 0; i < OUT_DEPTH; i++) begin : g_out
    tqc_cell u_cell (
      .clk (clk), .op (out_op[i]), .prev_key (out_prev[i]), .next_key (out_next[i]),
      .look_key (req_key_r), .key_o (out_key[i]), .match_o (out_eq[i])
    );
  end

  for (genvar i = 0; i < HOT_DEPTH; i++) begin : g_hot
    tqc_cell u_cell (
      .clk (clk), .op (hot_op[i]), .prev_key (hot_prev[i]), .next_key (hot_next[i]),
      .look_key (req_key_r), .key_o (hot_key[i]), .match_o (hot_eq[i])
    );
  end

  // Live-entry masking: only cells below the count take part in the lookup.
  always_comb begin
    for (int i = 0; i < IN_DEPTH; i++)  in_m[i]  = in_eq[i]  && (IN_CW'(i)  < in_eff);
    for (int i = 0; i < OUT_DEPTH; i++) out_m[i] = out_eq[i] && (OUT_CW'(i) < out_eff);
    for (int i = 0; i < HOT_DEPTH; i++) hot_m[i] = hot_eq[i] && (HOT_CW'(i) < hot_eff);
  end

  // Out removal closes the gap from the hit down: cells at or past the hit.
  // Hot promotion shifts cells from the head up to and including the hit.
  always_comb begin
    logic acc_o, acc_h;
    acc_o = 1'b0;
    for (int i = 0; i < OUT_DEPTH; i++) begin
      acc_o      = acc_o | out_m[i];
      out_pre[i] = acc_o;
    end
    acc_h = 1'b0;
    for (int i = HOT_DEPTH - 1; i >= 0; i--) begin
      acc_h      = acc_h | hot_m[i];
      hot_suf[i] = acc_h;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup decision (In wins over Out over Hot; live keys are distinct anyway)
  // ---------------------------------------------------------------------------
  logic hit_in, hit_out, hit_hot, miss, in_full;
  logic [IN_IW-1:0] in_tail;
  key_t moved_key;

  assign hit_in  = |in_m;
  assign hit_out = !hit_in && (|out_m);
  assign hit_hot = !hit_in && !hit_out && (|hot_m);
  assign miss    = !hit_in && !hit_out && !hit_hot;
  assign in_full = (in_eff >= lim.in_lim);

  // Oldest In entry that is still in use; leaves for Out on a full miss.
  assign in_tail   = IN_IW'(lim.in_lim - IN_CW'(1));
  assign moved_key = in_key[in_tail];

  always_comb begin
    if (hit_in)       region = REG_IN;
    else if (hit_out) region = REG_OUT;
    else if (hit_hot) region = REG_HOT;
    else              region = REG_MISS;
  end

  // Neighbor wiring: head takes the new key (Out: moved_key); tail's next is itself.
  always_comb begin
    for (int i = 0; i < IN_DEPTH; i++) begin
      in_prev[i] = (i == 0) ? req_key_r : in_key[(i == 0) ? 0 : i - 1];
      in_next[i] = in_key[(i == IN_DEPTH - 1) ? i : i + 1];
    end
    for (int i = 0; i < OUT_DEPTH; i++) begin
      out_prev[i] = (i == 0) ? moved_key : out_key[(i == 0) ? 0 : i - 1];
      out_next[i] = out_key[(i == OUT_DEPTH - 1) ? i : i + 1];
    end
    for (int i = 0; i < HOT_DEPTH; i++) begin
      hot_prev[i] = (i == 0) ? req_key_r : hot_key[(i == 0) ? 0 : i - 1];
      hot_next[i] = hot_key[(i == HOT_DEPTH - 1) ? i : i + 1];
    end
  end

  // Cell operations for this cycle.
  always_comb begin
    for (int i = 0; i < IN_DEPTH; i++)
      in_op[i] = (fire && miss) ? CELL_PREV : CELL_HOLD;
    for (int i = 0; i < OUT_DEPTH; i++) begin
      if (fire && miss && in_full)          out_op[i] = CELL_PREV;
      else if (fire && hit_out && out_pre[i]) out_op[i] = CELL_NEXT;
      else                                    out_op[i] = CELL_HOLD;
    end
    for (int i = 0; i < HOT_DEPTH; i++) begin
      if (fire && hit_out)                  hot_op[i] = CELL_PREV;
      else if (fire && hit_hot && hot_suf[i]) hot_op[i] = CELL_PREV;
      else                                    hot_op[i] = CELL_HOLD;
    end
  end

  // Count updates.
  always_comb begin
    in_cnt_nxt  = in_eff;
    out_cnt_nxt = out_eff;
    hot_cnt_nxt = hot_eff;
    if (fire) begin
      if (miss) begin
        in_cnt_nxt = in_full ? lim.in_lim : in_eff + IN_CW'(1);
        if (in_full)
          out_cnt_nxt = (out_eff >= lim.out_lim) ? lim.out_lim : out_eff + OUT_CW'(1);
      end
      if (hit_out) begin
        out_cnt_nxt = out_eff - OUT_CW'(1);
        hot_cnt_nxt = (hot_eff >= lim.hot_lim) ? lim.hot_lim : hot_eff + HOT_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      hot_cnt_r <= '0;
    end else begin
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      hot_cnt_r <= hot_cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/tqc_cell.sv =====
// One key slot of a list: holds a key, compares it, shifts toward head or tail.
module tqc_cell
  import tqc_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  key_t     prev_key,
  input  key_t     next_key,
  input  key_t     look_key,
  output key_t     key_o,
  output logic     match_o
);

  key_t key_r;
  key_t key_nxt;

  always_comb begin
    case (op)
      CELL_PREV: key_nxt = prev_key;
      CELL_NEXT: key_nxt = next_key;
      default:   key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o   = key_r;
  assign match_o = (key_r == look_key);

endmodule

// ===== rtl/core/tqc_cfg.sv =====
// APB register file for the three list limits.
module tqc_cfg
  import tqc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output lim_t              lim
);

  lim_t     lim_r;
  lim_t     lim_nxt;
  cfg_idx_t idx;
  logic     wr;

  assign idx = cfg_idx_t'(paddr[APB_AW-1:APB_AW-IDX_W]);
  assign wr  = psel && penable && pwrite;

  always_comb begin
    lim_nxt = lim_r;
    if (wr) begin
      unique case (idx)
        CFG_IN_LIMIT:  lim_nxt.in_lim  = IN_CW'(clamp_lim(
                         LIM_ARG_W'(pwdata[IN_LIM_FW-1:0]), IN_DEPTH));
        CFG_OUT_LIMIT: lim_nxt.out_lim = OUT_CW'(clamp_lim(
                         LIM_ARG_W'(pwdata[OUT_LIM_FW-1:0]), OUT_DEPTH));
        CFG_HOT_LIMIT: lim_nxt.hot_lim = HOT_CW'(clamp_lim(
                         LIM_ARG_W'(pwdata[HOT_LIM_FW-1:0]), HOT_DEPTH));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.in_lim  <= IN_CW'(clamp_lim(IN_LIM_RST, IN_DEPTH));
      lim_r.out_lim <= OUT_CW'(clamp_lim(OUT_LIM_RST, OUT_DEPTH));
      lim_r.hot_lim <= HOT_CW'(clamp_lim(HOT_LIM_RST, HOT_DEPTH));
    end else begin
      lim_r <= lim_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      CFG_IN_LIMIT:  prdata = APB_DW'(lim_r.in_lim);
      CFG_OUT_LIMIT: prdata = APB_DW'(lim_r.out_lim);
      CFG_HOT_LIMIT: prdata = APB_DW'(lim_r.hot_lim);
      default:       prdata = '0;
    endcase
  end

  assign lim = lim_r;

endmodule
